// ===== hw/rtl/csm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_pkg: shared types, constants and tables of the client signature matcher
// Signature table (lower-case byte codes), cell stage bus and helpers.
// ----------------------------------------------------------------------------
package csm_pkg;

  // Sizing
  localparam int SIG_COUNT     = 10;  // signatures tracked (1..32)
  localparam int SIG_MAX_LEN   = 11;  // longest signature compared (1..32)
  localparam int TABLE_SIZE    = 10;
  localparam int TABLE_MAX_LEN = 11;
  localparam int LIVE_COUNT    = (SIG_COUNT < TABLE_SIZE) ? SIG_COUNT : TABLE_SIZE;
  localparam int LEN_W         = $clog2(SIG_MAX_LEN + 1);
  localparam int BYTE_W        = 8;
  localparam int KIND_W        = 2;
  localparam int CODE_W        = 4;
  localparam int GROUP1_FIRST  = 6;   // first entry of the rpc group

  localparam logic [CODE_W-1:0] CODE_UNKNOWN = '0;
  localparam logic [CODE_W-1:0] CODE_MAX     = CODE_W'(TABLE_SIZE);

  // Response kinds
  localparam logic [KIND_W-1:0] KIND_VERSION_API = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RPC         = 2'd1;

  // Signature bytes, first character in the top byte, zero padded below
  localparam logic [8*TABLE_MAX_LEN-1:0] SIG_TEXT [TABLE_SIZE] = '{
    88'h226e696d627573_00000000,
    88'h226c6f646573746172_0000,
    88'h22707279736d_0000000000,
    88'h226c69676874686f757365,
    88'h2274656b75_000000000000,
    88'h226772616e64696e65_0000,
    88'h676574682f_000000000000,
    88'h6e65746865726d696e642f,
    88'h657269676f6e2f_00000000,
    88'h626573752f_000000000000
  };
  localparam int SIG_LEN [TABLE_SIZE] = '{7, 9, 6, 11, 5, 9, 5, 11, 7, 5};

  typedef logic [SIG_MAX_LEN-1:0][BYTE_W-1:0] pattern_t;

  // Word handed from one cell to the next
  typedef struct packed {
    logic                valid;
    logic [BYTE_W-1:0]   text_byte;
    logic [KIND_W-1:0]   kind;
    logic                final_byte;
    logic [CODE_W-1:0]   code;
  } stage_t;

  // Fold A-Z to lower case
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Effective length, cut to SIG_MAX_LEN
  function automatic logic [LEN_W-1:0] sig_len(input int s);
    return LEN_W'((SIG_LEN[s] > SIG_MAX_LEN) ? SIG_MAX_LEN : SIG_LEN[s]);
  endfunction

  // Character pattern of one signature, index 0 is the first character
  function automatic pattern_t sig_pattern(input int s);
    pattern_t p;
    int       n;
    p = '0;
    n = (SIG_LEN[s] > SIG_MAX_LEN) ? SIG_MAX_LEN : SIG_LEN[s];
    for (int i = 0; i < SIG_MAX_LEN; i++) begin
      if (i < n) begin
        p[i] = SIG_TEXT[s][8*(TABLE_MAX_LEN-1-i) +: 8];
      end
    end
    return p;
  endfunction

  // Response kind whose group holds a signature
  function automatic logic [KIND_W-1:0] sig_kind(input int s);
    return (s < GROUP1_FIRST) ? KIND_VERSION_API : KIND_RPC;
  endfunction

endpackage

// ===== hw/rtl/csm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_if: valid/ready channels of the client signature matcher
// Text byte channel in, client code channel out.
// ----------------------------------------------------------------------------
interface csm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic [1:0] response_kind;
  logic       final_byte;

  modport source (output valid, text_byte, response_kind, final_byte, input ready);
  modport sink   (input valid, text_byte, response_kind, final_byte, output ready);
endinterface

interface csm_code_if;
  logic       valid;
  logic       ready;
  logic [3:0] client_code;

  modport source (output valid, client_code, input ready);
  modport sink   (input valid, client_code, output ready);
endinterface

// ===== hw/rtl/csm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_cell: one signature tracker of the matcher chain
// Keeps the active-prefix vector and sticky seen flag of one signature,
// scans the word passing through and forwards it with the running code.
// ----------------------------------------------------------------------------
module csm_cell
  import csm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  stage_t                    stage_i,
  input  pattern_t                  pattern_i,
  input  logic [LEN_W-1:0]          pat_len_i,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic [CODE_W-1:0]         code_i,
  output stage_t                    stage_o
);

  logic [SIG_MAX_LEN-1:0] prog_q, prog_d, prog_nx, match;
  logic [SIG_MAX_LEN:0]   prog_sh;
  logic                   seen_q, seen_d, seen_nx, hit;
  logic [BYTE_W-1:0]      c;
  logic [CODE_W-1:0]      code_nx;
  logic                   valid_q;
  stage_t                 pay_q, pay_d;

  // Character compare against every position of the signature
  always_comb begin
    c   = fold_byte(stage_i.text_byte);
    hit = 1'b0;
    for (int i = 0; i < SIG_MAX_LEN; i++) begin
      match[i] = (pattern_i[i] == c) && (LEN_W'(i) < pat_len_i);
    end
    prog_sh = {prog_q, 1'b1};
    prog_nx = prog_sh[SIG_MAX_LEN-1:0] & match;
    for (int i = 0; i < SIG_MAX_LEN; i++) begin
      hit = hit | (prog_nx[i] && (LEN_W'(i + 1) == pat_len_i));
    end
    seen_nx = seen_q | hit;
  end

  // State update; a final word clears the tracker
  always_comb begin
    prog_d = prog_q;
    seen_d = seen_q;
    if (adv_i && stage_i.valid) begin
      if (stage_i.final_byte) begin
        prog_d = '0;
        seen_d = 1'b0;
      end else begin
        prog_d = prog_nx;
        seen_d = seen_nx;
      end
    end
  end

  // Earlier cells win: keep an upstream code, else offer ours
  always_comb begin
    code_nx = stage_i.code;
    if (stage_i.code == CODE_UNKNOWN && seen_nx && stage_i.kind == kind_i) begin
      code_nx = code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q  <= '0;
      seen_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      prog_q <= prog_d;
      seen_q <= seen_d;
      if (adv_i) begin
        valid_q <= stage_i.valid;
      end
    end
  end

  // Payload forward
  always_comb begin
    pay_d      = stage_i;
    pay_d.code = code_nx;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    stage_o       = pay_q;
    stage_o.valid = valid_q;
  end

endmodule

// ===== hw/rtl/client_signature_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_signature_matcher: case-insensitive client signature scanner
// Row of signature cells fed one text byte per word, with an output register.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while req_i.ready is high. Each byte walks down a chain of
// LIVE_COUNT cells (one per signature), so the result of a response passes
// through every cell register and then the output register after its final
// byte is accepted. Only the byte marked final yields a word: client_code is
// the earliest seen signature of the group picked by response_kind, or 0.
// req_i.ready drops only while a finished result sits at the end of the chain
// and the output register still holds an untaken word.
// ----------------------------------------------------------------------------
module client_signature_matcher
  import csm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  csm_text_if.sink          req_i,
  csm_code_if.source        rsp_o
);

  stage_t            chain [LIVE_COUNT+1];
  stage_t            tail;
  logic              adv, tail_res;
  logic              out_valid_q;
  logic [CODE_W-1:0] out_code_q;

  // Chain entry
  always_comb begin
    chain[0].valid      = req_i.valid;
    chain[0].text_byte  = req_i.text_byte;
    chain[0].kind       = req_i.response_kind;
    chain[0].final_byte = req_i.final_byte;
    chain[0].code       = CODE_UNKNOWN;
  end

  // Cell row
  for (genvar g = 0; g < LIVE_COUNT; g++) begin : g_cell
    localparam pattern_t PAT = sig_pattern(g);
    csm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .stage_i   (chain[g]),
      .pattern_i (PAT),
      .pat_len_i (sig_len(g)),
      .kind_i    (sig_kind(g)),
      .code_i    (CODE_W'(g + 1)),
      .stage_o   (chain[g+1])
    );
  end

  // Stall only when a result cannot be placed
  assign tail     = chain[LIVE_COUNT];
  assign tail_res = tail.valid && tail.final_byte;
  assign adv      = !(tail_res && out_valid_q && !rsp_o.ready);
  assign req_i.ready = adv;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (adv && tail_res) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail_res) begin
      out_code_q <= tail.code;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.client_code = out_code_q;

endmodule

// ===== hw/rtl/csm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_checker: port-level checks of the client signature matcher
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module csm_checker
  import csm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [CODE_W-1:0] rsp_code_i
);

  // A held result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result word dropped before taken");

  // A held result word keeps its code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_code_i))
    else $error("result code changed while stalled");

  // Input backpressure only comes from a blocked output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("input stalled without output backpressure");

  // Codes stay within the signature table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_code_i <= CODE_MAX)
    else $error("client code out of range");

endmodule

bind client_signature_matcher csm_checker u_csm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_code_i  (rsp_o.client_code)
);

// ===== dv/client_code_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_code_checker: predicts and checks the client code words
// Watches both channels. Every accepted text byte runs through a local
// signature scanner, and each final byte queues the client code the scanner
// expects. Every accepted code word is compared with the oldest queued code.
// ----------------------------------------------------------------------------
module client_code_checker
  import csm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  csm_text_if  text_ch,
  csm_code_if  code_ch,
  output int   mismatch_count_o,
  output int   codes_pending_o
);

  localparam int NUM_SIGS     = 10;
  localparam int SIG_ROW_LEN  = 11;
  localparam int TRACKED_SIGS = (SIG_COUNT < NUM_SIGS) ? SIG_COUNT : NUM_SIGS;

  // Lower-case signature bytes, zero padded
  localparam logic [7:0] SIGNATURE [NUM_SIGS][SIG_ROW_LEN] = '{
    '{8'h22, 8'h6e, 8'h69, 8'h6d, 8'h62, 8'h75, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h22, 8'h6c, 8'h6f, 8'h64, 8'h65, 8'h73, 8'h74, 8'h61, 8'h72, 8'h00, 8'h00},
    '{8'h22, 8'h70, 8'h72, 8'h79, 8'h73, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h22, 8'h6c, 8'h69, 8'h67, 8'h68, 8'h74, 8'h68, 8'h6f, 8'h75, 8'h73, 8'h65},
    '{8'h22, 8'h74, 8'h65, 8'h6b, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h22, 8'h67, 8'h72, 8'h61, 8'h6e, 8'h64, 8'h69, 8'h6e, 8'h65, 8'h00, 8'h00},
    '{8'h67, 8'h65, 8'h74, 8'h68, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6e, 8'h65, 8'h74, 8'h68, 8'h65, 8'h72, 8'h6d, 8'h69, 8'h6e, 8'h64, 8'h2f},
    '{8'h65, 8'h72, 8'h69, 8'h67, 8'h6f, 8'h6e, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h62, 8'h65, 8'h73, 8'h75, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int SIGNATURE_LEN [NUM_SIGS] = '{7, 9, 6, 11, 5, 9, 5, 11, 7, 5};

  // Scanner state: active prefixes per signature, sticky seen flags
  logic [SIG_MAX_LEN-1:0] prefix_live [NUM_SIGS];
  logic [NUM_SIGS-1:0]    sig_seen;

  logic [CODE_W-1:0] client_code_q [$];
  logic [CODE_W-1:0] want_code;
  int                mismatches;

  task automatic clear_scan_state();
    for (int s = 0; s < NUM_SIGS; s++) begin
      prefix_live[s] = '0;
    end
    sig_seen = '0;
  endtask

  // Advance every tracked signature by one byte; on the final byte queue
  // the earliest seen signature of the group the kind selects
  task automatic scan_text_byte(input logic [7:0] raw, input logic [KIND_W-1:0] kind,
                                input logic fin);
    logic [7:0]             c;
    logic [SIG_MAX_LEN-1:0] hits;
    logic [SIG_MAX_LEN-1:0] live;
    logic [CODE_W-1:0]      code;
    int                     len;
    int                     lo;
    int                     hi;
    c = (raw >= 8'h41 && raw <= 8'h5a) ? raw + 8'h20 : raw;
    for (int s = 0; s < TRACKED_SIGS; s++) begin
      len  = (SIGNATURE_LEN[s] > SIG_MAX_LEN) ? SIG_MAX_LEN : SIGNATURE_LEN[s];
      hits = '0;
      for (int i = 0; i < len; i++) begin
        if (SIGNATURE[s][i] == c) hits[i] = 1'b1;
      end
      live           = ((prefix_live[s] << 1) | SIG_MAX_LEN'(1)) & hits;
      prefix_live[s] = live;
      if (len > 0 && live[len-1]) sig_seen[s] = 1'b1;
    end
    if (fin) begin
      code = CODE_UNKNOWN;
      lo   = 0;
      hi   = 0;
      if (kind == KIND_VERSION_API) begin
        hi = GROUP1_FIRST;
      end else if (kind == KIND_RPC) begin
        lo = GROUP1_FIRST;
        hi = NUM_SIGS;
      end
      // walk down so the lowest seen index is the one left in code
      for (int s = hi - 1; s >= lo; s--) begin
        if (s < TRACKED_SIGS && sig_seen[s]) code = CODE_W'(s + 1);
      end
      client_code_q.push_back(code);
      clear_scan_state();
    end
  endtask

  // Monitor: check outgoing codes first, then scan the incoming byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan_state();
      client_code_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      codes_pending_o  <= 0;
    end else begin
      if (code_ch.valid && code_ch.ready) begin
        if (client_code_q.size() == 0) begin
          $display("%t: client_code expected none, actual %0d", $time, code_ch.client_code);
          mismatches++;
        end else begin
          want_code = client_code_q.pop_front();
          if (code_ch.client_code !== want_code) begin
            $display("%t: client_code expected %0d, actual %0d", $time, want_code,
                     code_ch.client_code);
            mismatches++;
          end
        end
      end
      if (text_ch.valid && text_ch.ready) begin
        scan_text_byte(text_ch.text_byte, text_ch.response_kind, text_ch.final_byte);
      end
      mismatch_count_o <= mismatches;
      codes_pending_o  <= client_code_q.size();
    end
  end

endmodule

// ===== dv/tb_client_signature_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_client_signature_matcher: testbench of the client signature matcher
// Sends response texts one byte per word: a few directed responses, then
// random responses built from filler, partial and whole signatures in mixed
// case. Both channels idle at random. A checker beside the block predicts
// every client code and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_client_signature_matcher;
  import csm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam int RANDOM_WORDS = 600;
  localparam int TAIL_CYCLES  = 3 * (LIVE_COUNT + 1);
  localparam int DRAIN_LIMIT  = 5000;

  typedef logic [7:0] text_q_t [$];

  logic clk_i;
  logic rst_ni;
  logic steady;         // no idling on either side while set
  int   mismatch_count;
  int   codes_pending;
  int   words_sent;

  csm_text_if text_ch();
  csm_code_if code_ch();

  client_signature_matcher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (text_ch),
    .rsp_o  (code_ch)
  );

  client_code_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .text_ch          (text_ch),
    .code_ch          (code_ch),
    .mismatch_count_o (mismatch_count),
    .codes_pending_o  (codes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Code side stalls at random
  always @(posedge clk_i) begin
    code_ch.ready <= steady || ($urandom_range(99) >= 34);
  end

  // Append the first cut bytes of a signature, letters in random case
  task automatic add_signature(ref text_q_t txt, input int s, input int cut);
    logic [7:0] b;
    for (int i = 0; i < cut && i < SIG_LEN[s]; i++) begin
      b = SIG_TEXT[s][8*(TABLE_MAX_LEN-1-i) +: 8];
      if (b >= 8'h61 && b <= 8'h7a && $urandom_range(1) == 1) b = b - 8'h20;
      txt.push_back(b);
    end
  endtask

  // Noise bytes: mostly random, some signature characters, rarely NUL
  task automatic add_filler(ref text_q_t txt, input int n);
    int s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(49)) inside
        0: begin
          txt.push_back(8'h00);
        end
        [1:15]: begin
          s = $urandom_range(TABLE_SIZE - 1);
          txt.push_back(SIG_TEXT[s][8*(TABLE_MAX_LEN-1-$urandom_range(SIG_LEN[s]-1)) +: 8]);
        end
        default: begin
          txt.push_back(8'($urandom_range(255, 1)));
        end
      endcase
    end
  endtask

  // Ready only changes at clock edges, so it is sampled mid-cycle
  task automatic send_word(input logic [7:0] b, input logic [KIND_W-1:0] kind,
                           input logic fin);
    logic acc;
    while (!steady && $urandom_range(99) < 34) begin
      text_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_ch.valid         <= 1'b1;
    text_ch.text_byte     <= b;
    text_ch.response_kind <= kind;
    text_ch.final_byte    <= fin;
    do begin
      @(negedge clk_i);
      acc = text_ch.ready;
      @(posedge clk_i);
    end while (!acc);
    words_sent++;
  endtask

  // Kind is random on inner bytes; only the final byte carries the real one
  task automatic send_response(input text_q_t txt, input logic [KIND_W-1:0] kind);
    int last;
    last = txt.size() - 1;
    foreach (txt[i]) begin
      send_word(txt[i], (i == last) ? kind : KIND_W'($urandom_range(3)), i == last);
    end
  endtask

  // Hold the text side until every predicted code has come out
  task automatic wait_for_codes();
    int guard;
    guard = 0;
    text_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (codes_pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic random_response(output text_q_t txt, output logic [KIND_W-1:0] kind);
    int s;
    int pick;
    txt = {};
    if ($urandom_range(9) == 0) begin
      add_filler(txt, 1);
    end else begin
      add_filler(txt, $urandom_range(4));
      repeat ($urandom_range(2)) begin
        s = $urandom_range(TABLE_SIZE - 1);
        if ($urandom_range(3) == 0) add_signature(txt, s, $urandom_range(SIG_LEN[s] - 1, 1));
        if ($urandom_range(4) != 0) add_signature(txt, s, SIG_LEN[s]);
        add_filler(txt, $urandom_range(3));
      end
      if (txt.size() == 0) add_filler(txt, 1);
    end
    pick = $urandom_range(19);
    if (pick < 9) kind = KIND_VERSION_API;
    else if (pick < 18) kind = KIND_RPC;
    else if (pick == 18) kind = KIND_OTHER;
    else kind = KIND_RESERVED;
  endtask

  initial begin
    text_q_t             txt;
    logic [KIND_W-1:0]   kind;
    int                  start;
    int                  n;
    rst_ni                = 1'b0;
    steady                = 1'b0;
    words_sent            = 0;
    text_ch.valid         = 1'b0;
    text_ch.text_byte     = '0;
    text_ch.response_kind = '0;
    text_ch.final_byte    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single byte response, top byte value, other kind
    txt = '{8'hff};
    send_response(txt, KIND_OTHER);
    // First version-api signature, mixed case
    txt = {};
    add_signature(txt, 0, SIG_LEN[0]);
    send_response(txt, KIND_VERSION_API);
    // Two rpc signatures split by NUL and 0x01: earlier list entry wins
    txt = {};
    add_signature(txt, 9, SIG_LEN[9]);
    txt.push_back(8'h00);
    txt.push_back(8'h01);
    add_signature(txt, 6, SIG_LEN[6]);
    send_response(txt, KIND_RPC);
    // Kind three reports unknown even with a signature present
    txt = {};
    add_signature(txt, 4, SIG_LEN[4]);
    send_response(txt, KIND_RESERVED);
    wait_for_codes();

    // Random responses
    start = words_sent;
    n     = 0;
    while (words_sent - start < RANDOM_WORDS) begin
      steady = (n >= 12 && n < 20);
      random_response(txt, kind);
      send_response(txt, kind);
      n++;
      if (n % 16 == 0) wait_for_codes();
    end
    steady = 1'b0;

    wait_for_codes();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (codes_pending != 0) begin
      $display("%t: %0d client codes never arrived", $time, codes_pending);
    end
    if (mismatch_count == 0 && codes_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== client_signature_matcher.f =====
hw/rtl/csm_pkg.sv
hw/rtl/csm_if.sv
hw/rtl/csm_cell.sv
hw/rtl/client_signature_matcher.sv
hw/rtl/csm_checker.sv
dv/client_code_checker.sv
dv/tb_client_signature_matcher.sv
